// ----- rtl/shared_ring_message_queue_pointers_assert.svh -----
// ----------------------------------------------------------------------------
// shared ring message queue pointers: assertion macros
// immediate-consequence and next-cycle implications, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef SHARED_RING_MESSAGE_QUEUE_POINTERS_ASSERT_SVH
`define SHARED_RING_MESSAGE_QUEUE_POINTERS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SRMQ_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("srmq assertion failed");

// antecedent implies consequent in the next cycle
`define SRMQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("srmq assertion failed");

`endif

// ----- rtl/srmq_pkg.sv -----
// ----------------------------------------------------------------------------
// srmq_pkg
// types, widths and codes shared by the ring message queue pointer block
// ----------------------------------------------------------------------------
package srmq_pkg;

  localparam int PTR_W       = 12;
  localparam int MC_W        = 13;
  localparam int SIZE_W      = 17;
  localparam int BASE_W      = 48;
  localparam int PROD_W      = MC_W + SIZE_W;
  localparam int FUNC_W      = 3;
  localparam int APB_DATA_W  = 64;
  localparam int APB_ADDR_W  = 5;
  localparam int REG_IDX_W   = 2;

  localparam int MAX_SLOTS_DEF = 4096;

  // config reset values
  localparam logic [MC_W-1:0]   MSG_COUNT_RST = MC_W'(16);
  localparam logic [SIZE_W-1:0] MSG_SIZE_RST  = SIZE_W'(256);

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_MSG_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MSG_SIZE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TX_BASE   = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RX_BASE   = 2'd3;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_TX_LINK    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RX_LINK    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_GET_WRITE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SUBMIT     = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_AVAILABLE  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_GET_READ   = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_CONSUME    = 3'd6;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PTR_W-1:0]  amount;
    logic [PTR_W-1:0]  remote_read_ptr;
    logic [PTR_W-1:0]  remote_write_ptr;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [PTR_W-1:0]  slot;
    logic [BASE_W-1:0] byte_address;
    logic [PTR_W-1:0]  available;
    logic              publish;
    logic [PTR_W-1:0]  published_ptr;
  } out_t;

  typedef struct packed {
    logic [MC_W-1:0]   msg_count;
    logic [SIZE_W-1:0] msg_size;
    logic [BASE_W-1:0] tx_entry_base;
    logic [BASE_W-1:0] rx_entry_base;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic exec;
    logic mul;
    logic fin;
  } dp_cmd_t;

  typedef struct packed {
    logic addr_en;
  } dp_status_t;

endpackage

// ----- rtl/srmq_regs.sv -----
// ----------------------------------------------------------------------------
// srmq_regs
// configuration register file behind the apb port
// ----------------------------------------------------------------------------
module srmq_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [srmq_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [srmq_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [srmq_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output srmq_pkg::cfg_t                     cfg_o
);

  srmq_pkg::cfg_t                     cfg_q;
  logic [srmq_pkg::REG_IDX_W-1:0]     idx;
  logic                               wr_en;

  // registers sit on 8-byte boundaries
  assign idx   = paddr[srmq_pkg::APB_ADDR_W-1:3];
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.msg_count     <= srmq_pkg::MSG_COUNT_RST;
      cfg_q.msg_size      <= srmq_pkg::MSG_SIZE_RST;
      cfg_q.tx_entry_base <= '0;
      cfg_q.rx_entry_base <= '0;
    end else if (wr_en) begin
      case (idx)
        srmq_pkg::REG_MSG_COUNT: cfg_q.msg_count <= pwdata[srmq_pkg::MC_W-1:0];
        srmq_pkg::REG_MSG_SIZE:  cfg_q.msg_size  <= pwdata[srmq_pkg::SIZE_W-1:0];
        srmq_pkg::REG_TX_BASE:   cfg_q.tx_entry_base <= pwdata[srmq_pkg::BASE_W-1:0];
        srmq_pkg::REG_RX_BASE:   cfg_q.rx_entry_base <= pwdata[srmq_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      srmq_pkg::REG_MSG_COUNT:
        prdata = {{(srmq_pkg::APB_DATA_W - srmq_pkg::MC_W){1'b0}}, cfg_q.msg_count};
      srmq_pkg::REG_MSG_SIZE:
        prdata = {{(srmq_pkg::APB_DATA_W - srmq_pkg::SIZE_W){1'b0}}, cfg_q.msg_size};
      srmq_pkg::REG_TX_BASE:
        prdata = {{(srmq_pkg::APB_DATA_W - srmq_pkg::BASE_W){1'b0}}, cfg_q.tx_entry_base};
      srmq_pkg::REG_RX_BASE:
        prdata = {{(srmq_pkg::APB_DATA_W - srmq_pkg::BASE_W){1'b0}}, cfg_q.rx_entry_base};
      default:
        prdata = '0;
    endcase
  end

endmodule

// ----- rtl/srmq_ctrl.sv -----
// ----------------------------------------------------------------------------
// srmq_ctrl
// sequencer for one queue operation: load, refresh, execute, multiply, finish
// ----------------------------------------------------------------------------
module srmq_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  output logic                    done_o,
  output srmq_pkg::dp_cmd_t       cmd_o,
  input  srmq_pkg::dp_status_t    status_i
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       done_q;

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

  // commands use only state and start, so the datapath status never loops back
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        // only a granted get needs the slot address
        state_d = status_i.addr_en ? ST_MUL : ST_FIN;
      end
      ST_MUL: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_FIN);
    end
  end

endmodule

// ----- rtl/srmq_dp.sv -----
// ----------------------------------------------------------------------------
// srmq_dp
// pointer state, ring difference unit, slot wrap and slot address datapath
// ----------------------------------------------------------------------------
module srmq_dp #(
  parameter int MAX_SLOTS = srmq_pkg::MAX_SLOTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  srmq_pkg::dp_cmd_t       cmd_i,
  input  srmq_pkg::in_t           item_i,
  input  srmq_pkg::cfg_t          cfg_i,
  output srmq_pkg::dp_status_t    status_o,
  output srmq_pkg::out_t          res_o
);

  localparam int PW = srmq_pkg::PTR_W;
  localparam int MW = srmq_pkg::MC_W;
  localparam int DW = srmq_pkg::MC_W + 1;
  localparam int QW = srmq_pkg::PROD_W;
  localparam int BW = srmq_pkg::BASE_W;
  localparam int CountMax = (1 << MW) - 1;
  localparam int McMax = (MAX_SLOTS > CountMax) ? CountMax : MAX_SLOTS;

  // latched operation
  logic [srmq_pkg::FUNC_W-1:0] func_q;
  logic [PW-1:0] amount_q, rrp_q, rwp_q;
  logic [MW-1:0] mc_q, mc_cfg;

  // queue state
  logic [PW-1:0] tx_wp_q, tx_wp_d, tx_free_q, tx_free_d;
  logic [PW-1:0] rx_rp_q, rx_rp_d, rx_avail_q, rx_avail_d;
  logic          tx_linked_q, tx_linked_d, rx_linked_q, rx_linked_d;
  logic          nofit_q, nofit_d;

  // operation results
  logic          ok_q, ok_d, pub_q, pub_d, addr_en_q, addr_en_d;
  logic [MW-1:0] slot_q, slot_d;
  logic [PW-1:0] avail_q, avail_d, pptr_q, pptr_d;
  logic [QW-1:0] prod_q;
  srmq_pkg::out_t res_q;

  // ring difference unit
  logic          use_tx, remote_bad;
  logic [PW-1:0] d_a, d_b, diff;
  logic [DW-1:0] d_top, d_t, d_t2;

  // wrapped pointer sums
  logic [MW-1:0] tx_sum, tx_sum2, tx_wrap, rx_sum, rx_sum2, rx_wrap;
  logic [PW-1:0] tx_sat, rx_sat;
  logic [BW-1:0] base, addr_sum;

  always_comb begin
    if (cfg_i.msg_count < MW'(2)) begin
      mc_cfg = MW'(2);
    end else if (cfg_i.msg_count > MW'(McMax)) begin
      mc_cfg = MW'(McMax);
    end else begin
      mc_cfg = cfg_i.msg_count;
    end
  end

  // tx: rrp + mc - 1 - wp ; rx: rwp + mc - rp ; both saturate and wrap once
  always_comb begin
    use_tx     = (func_q == srmq_pkg::FUNC_GET_WRITE);
    d_a        = use_tx ? rrp_q : rwp_q;
    d_b        = use_tx ? tx_wp_q : rx_rp_q;
    remote_bad = ({1'b0, d_a} >= mc_q);
    d_top      = {2'b00, d_a} + {1'b0, mc_q} - {{(DW-1){1'b0}}, use_tx};
    d_t        = d_top - {2'b00, d_b};
    d_t2       = d_t - {1'b0, mc_q};
    if ({2'b00, d_b} >= d_top) begin
      diff = '0;
    end else if (d_t >= {1'b0, mc_q}) begin
      diff = d_t2[PW-1:0];
    end else begin
      diff = d_t[PW-1:0];
    end
  end

  always_comb begin
    tx_sum  = {1'b0, tx_wp_q} + {1'b0, amount_q};
    tx_sum2 = tx_sum - mc_q;
    tx_wrap = (tx_sum >= mc_q) ? tx_sum2 : tx_sum;
    rx_sum  = {1'b0, rx_rp_q} + {1'b0, amount_q};
    rx_sum2 = rx_sum - mc_q;
    rx_wrap = (rx_sum >= mc_q) ? rx_sum2 : rx_sum;
    tx_sat  = (tx_free_q > amount_q) ? (tx_free_q - amount_q) : '0;
    rx_sat  = (rx_avail_q > amount_q) ? (rx_avail_q - amount_q) : '0;
  end

  always_comb begin
    tx_wp_d     = tx_wp_q;
    tx_free_d   = tx_free_q;
    rx_rp_d     = rx_rp_q;
    rx_avail_d  = rx_avail_q;
    tx_linked_d = tx_linked_q;
    rx_linked_d = rx_linked_q;
    nofit_d     = nofit_q;
    ok_d        = 1'b0;
    pub_d       = 1'b0;
    addr_en_d   = 1'b0;
    slot_d      = '0;
    avail_d     = '0;
    pptr_d      = '0;

    if (cmd_i.eval) begin
      // refresh the cached count from the partner pointer where needed
      nofit_d = 1'b0;
      case (func_q)
        srmq_pkg::FUNC_GET_WRITE: begin
          if (tx_linked_q && (amount_q >= tx_free_q)) begin
            if (remote_bad) nofit_d = 1'b1;
            else            tx_free_d = diff;
          end
        end
        srmq_pkg::FUNC_AVAILABLE: begin
          if (rx_linked_q) begin
            if (remote_bad) nofit_d = 1'b1;
            else            rx_avail_d = diff;
          end
        end
        srmq_pkg::FUNC_GET_READ: begin
          if (rx_linked_q && (amount_q >= rx_avail_q)) begin
            if (remote_bad) nofit_d = 1'b1;
            else            rx_avail_d = diff;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.exec) begin
      case (func_q)
        srmq_pkg::FUNC_TX_LINK: begin
          if (!tx_linked_q) begin
            tx_linked_d = 1'b1;
            tx_wp_d     = '0;
            tx_free_d   = mc_q[PW-1:0] - PW'(1);
            ok_d        = 1'b1;
            pub_d       = 1'b1;
          end
        end
        srmq_pkg::FUNC_RX_LINK: begin
          if (!rx_linked_q) begin
            rx_linked_d = 1'b1;
            rx_rp_d     = '0;
            ok_d        = 1'b1;
            pub_d       = 1'b1;
          end
        end
        srmq_pkg::FUNC_GET_WRITE: begin
          // slot may still land beyond the ring after one wrap
          if (tx_linked_q && !nofit_q && (amount_q < tx_free_q) && (tx_wrap < mc_q)) begin
            ok_d      = 1'b1;
            slot_d    = tx_wrap;
            addr_en_d = 1'b1;
          end
        end
        srmq_pkg::FUNC_SUBMIT: begin
          if (tx_linked_q) begin
            tx_wp_d   = tx_wrap[PW-1:0];
            tx_free_d = tx_sat;
            ok_d      = 1'b1;
            pub_d     = 1'b1;
            pptr_d    = tx_wrap[PW-1:0];
          end
        end
        srmq_pkg::FUNC_AVAILABLE: begin
          if (rx_linked_q && !nofit_q) begin
            ok_d    = 1'b1;
            avail_d = rx_avail_q;
          end
        end
        srmq_pkg::FUNC_GET_READ: begin
          if (rx_linked_q && !nofit_q && (amount_q < rx_avail_q)) begin
            ok_d      = 1'b1;
            slot_d    = {1'b0, rx_wrap[PW-1:0]};
            addr_en_d = 1'b1;
          end
        end
        srmq_pkg::FUNC_CONSUME: begin
          if (rx_linked_q) begin
            rx_rp_d    = rx_wrap[PW-1:0];
            rx_avail_d = rx_sat;
            ok_d       = 1'b1;
            pub_d      = 1'b1;
            pptr_d     = rx_wrap[PW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign status_o.addr_en = addr_en_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_wp_q     <= '0;
      tx_free_q   <= '0;
      rx_rp_q     <= '0;
      rx_avail_q  <= '0;
      tx_linked_q <= 1'b0;
      rx_linked_q <= 1'b0;
      nofit_q     <= 1'b0;
    end else begin
      tx_wp_q     <= tx_wp_d;
      tx_free_q   <= tx_free_d;
      rx_rp_q     <= rx_rp_d;
      rx_avail_q  <= rx_avail_d;
      tx_linked_q <= tx_linked_d;
      rx_linked_q <= rx_linked_d;
      nofit_q     <= nofit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q   <= item_i.func;
      amount_q <= item_i.amount;
      rrp_q    <= item_i.remote_read_ptr;
      rwp_q    <= item_i.remote_write_ptr;
      mc_q     <= mc_cfg;
    end
    if (cmd_i.exec) begin
      ok_q      <= ok_d;
      pub_q     <= pub_d;
      addr_en_q <= addr_en_d;
      slot_q    <= slot_d;
      avail_q   <= avail_d;
      pptr_q    <= pptr_d;
    end
    if (cmd_i.mul) begin
      prod_q <= {{(QW-MW){1'b0}}, slot_q} *
                {{(QW-srmq_pkg::SIZE_W){1'b0}}, cfg_i.msg_size};
    end
    if (cmd_i.fin) begin
      res_q.ok            <= ok_q;
      res_q.slot          <= slot_q[PW-1:0];
      res_q.byte_address  <= addr_en_q ? addr_sum : '0;
      res_q.available     <= avail_q;
      res_q.publish       <= pub_q;
      res_q.published_ptr <= pptr_q;
    end
  end

  assign base     = (func_q == srmq_pkg::FUNC_GET_WRITE) ? cfg_i.tx_entry_base
                                                         : cfg_i.rx_entry_base;
  assign addr_sum = base + {{(BW-QW){1'b0}}, prod_q};
  assign res_o    = res_q;

endmodule

// ----- rtl/shared_ring_message_queue_pointers.sv -----
// ----------------------------------------------------------------------------
// shared_ring_message_queue_pointers
// transmit and receive pointer keeper of a shared ring message queue
// ----------------------------------------------------------------------------
// channel   ports                                  handshake
// command   start, busy, cmd_i                     taken when start and !busy
// result    done_o, res_o                          one-cycle strobe, no stall
// config    psel, penable, pwrite, paddr, pwdata   apb write on access phase
//
// an operation steps through refresh, execute and finish to its result strobe;
// a granted get adds the slot times message size multiply; the 48-bit
// base add sits in the final step. busy stays high until the result cycle,
// when a new command may already be taken. reset clears both link flags,
// pointers and cached counts; config registers return to their defaults.
// ----------------------------------------------------------------------------
module shared_ring_message_queue_pointers #(
  parameter int MAX_SLOTS = srmq_pkg::MAX_SLOTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  srmq_pkg::in_t                    cmd_i,
  output logic                             done_o,
  output srmq_pkg::out_t                   res_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srmq_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [srmq_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [srmq_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  srmq_pkg::cfg_t        cfg;
  srmq_pkg::dp_cmd_t     dp_cmd;
  srmq_pkg::dp_status_t  dp_status;

  srmq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srmq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .cmd_o    (dp_cmd),
    .status_i (dp_status)
  );

  srmq_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (dp_cmd),
    .item_i   (cmd_i),
    .cfg_i    (cfg),
    .status_o (dp_status),
    .res_o    (res_o)
  );

endmodule

// ----- rtl/srmq_checker.sv -----
// ----------------------------------------------------------------------------
// srmq_checker
// port-level checks on command sequencing and result contents
// ----------------------------------------------------------------------------
`include "shared_ring_message_queue_pointers_assert.svh"

module srmq_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input srmq_pkg::out_t  res_o
);

  logic accept;
  logic res_clear;

  assign accept = start & ~busy;
  assign res_clear = (res_o.slot == '0) && (res_o.byte_address == '0) &&
                     (res_o.available == '0) && !res_o.publish &&
                     (res_o.published_ptr == '0);

  // a transaction starts the sequencer, and no result follows immediately
  `SRMQ_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy && !done_o)
  // the result cycle already frees the command side
  `SRMQ_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // a strobe lasts one cycle
  `SRMQ_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)
  // a refused operation reports nothing else
  `SRMQ_ASSERT_SAME(a_refused_clear, clk_i, rst_ni, done_o && !res_o.ok, res_clear)

endmodule

bind shared_ring_message_queue_pointers srmq_checker u_srmq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
